// ----- rtl/core/utf8sc_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8sc_pkg
// shared types, reason codes and the lead byte decoder for the utf-8 checker
// ----------------------------------------------------------------------------
package utf8sc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BUDGET_W = 16;
   localparam int unsigned REASON_W = 3;
   localparam int unsigned OWED_W   = 3;
   localparam int unsigned CSR_IDX_W = 1;

   // verdict reasons
   localparam logic [REASON_W-1:0] REASON_VALID     = 3'd0;
   localparam logic [REASON_W-1:0] REASON_ALL_ASCII = 3'd1;
   localparam logic [REASON_W-1:0] REASON_BAD_LEAD  = 3'd2;
   localparam logic [REASON_W-1:0] REASON_BAD_CONT  = 3'd3;
   localparam logic [REASON_W-1:0] REASON_TRUNCATED = 3'd4;
   localparam logic [REASON_W-1:0] REASON_BUDGET    = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_BUDGET  = 1'd1;

   // one request: a byte and its end-of-string flag
   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              is_last;
   } item_type;

   // sequence length of a byte with bit 7 set, zero for a continuation byte
   // 0xfe and 0xff open five-byte sequences
   function automatic logic [OWED_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [OWED_W-1:0] n;
      begin
         if (b[7:1] == 7'b1111110)       n = 3'd6;
         else if (b[7:3] == 5'b11111)    n = 3'd5;
         else if (b[7:4] == 4'b1111)     n = 3'd4;
         else if (b[7:5] == 3'b111)      n = 3'd3;
         else if (b[7:6] == 2'b11)       n = 3'd2;
         else                            n = 3'd0;
         return n;
      end
   endfunction

endpackage

// ----- rtl/core/utf8_stream_checker.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_checker
// checks a byte string for utf-8 (old form, up to six bytes per sequence)
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    req_byte_in, req_is_last
//  rsp       out        rsp_valid/rsp_ready    rsp_is_utf8, rsp_reason
//  csr       in         csr_write_en           csr_index, csr_wdata
//
//  one byte per cycle while the rsp side does not stall; a byte is registered
//  on entry and judged from the input register, and the verdict of a string
//  is registered in the result register.
//  only the last byte of a string needs the result register to be free; a
//  stalled rsp side holds back a last byte and, behind it, the req side.
//  reset is synchronous; it clears all string state, settings and valid flags.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [utf8sc_pkg::BYTE_W-1:0]        req_byte_in,
   input  logic                                 req_is_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_utf8,
   output logic [utf8sc_pkg::REASON_W-1:0]      rsp_reason,
   input  logic                                 csr_write_en,
   input  logic [utf8sc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [utf8sc_pkg::BUDGET_W-1:0]      csr_wdata
);
   import utf8sc_pkg::*;

   logic                limit_enable_ff;
   logic [BUDGET_W-1:0] char_budget_ff;
   item_type            req_item;
   item_type            held_item;
   logic                held_valid;
   logic                held_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         char_budget_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LIMIT_ENABLE: limit_enable_ff <= csr_wdata[0];
            CSR_CHAR_BUDGET:  char_budget_ff  <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign req_item.byte_in = req_byte_in;
   assign req_item.is_last = req_is_last;

   // input register
   utf8sc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_item  (held_item),
      .out_take  (held_take)
   );

   // string evaluation and result register
   utf8sc_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .limit_enable (limit_enable_ff),
      .char_budget  (char_budget_ff),
      .item_valid   (held_valid),
      .item         (held_item),
      .item_take    (held_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_utf8  (rsp_is_utf8),
      .rsp_reason   (rsp_reason)
   );

endmodule

// ----- rtl/core/utf8sc_in_reg.sv -----
// ----------------------------------------------------------------------------
// utf8sc_in_reg
// input register stage: holds one request until the evaluator takes it
// ----------------------------------------------------------------------------
module utf8sc_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  utf8sc_pkg::item_type in_item,
   output logic                 out_valid,
   output utf8sc_pkg::item_type out_item,
   input  logic                 out_take
);
   import utf8sc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // free when empty or when the held request leaves this cycle
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- rtl/core/utf8sc_eval.sv -----
// ----------------------------------------------------------------------------
// utf8sc_eval
// per-string state update and result register, one byte per cycle unless a last byte waits for the result register
// ----------------------------------------------------------------------------
module utf8sc_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                limit_enable,
   input  logic [utf8sc_pkg::BUDGET_W-1:0]     char_budget,
   input  logic                                item_valid,
   input  utf8sc_pkg::item_type                item,
   output logic                                item_take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_utf8,
   output logic [utf8sc_pkg::REASON_W-1:0]     rsp_reason
);
   import utf8sc_pkg::*;

   logic [OWED_W-1:0]   owed_ff, owed_in;
   logic                ascii_ff, ascii_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic                fixed_ff, fixed_in;
   logic                fverdict_ff, fverdict_in;
   logic [REASON_W-1:0] freason_ff, freason_in;
   logic                mid_ff, mid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_utf8_ff, rsp_utf8_in;
   logic [REASON_W-1:0] rsp_reason_ff, rsp_reason_in;

   logic                out_free;
   logic                high;
   logic [OWED_W-1:0]   lead_n;
   logic [OWED_W-1:0]   s_owed;
   logic                s_ascii;
   logic [BUDGET_W-1:0] s_budget;
   logic                s_fixed;
   logic                s_fverdict;
   logic [REASON_W-1:0] s_freason;

   // a last byte needs room in the result register, others always pass
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_take = item_valid && (!item.is_last || out_free);

   assign high   = item.byte_in[7];
   assign lead_n = lead_length(item.byte_in);

   // state after this byte
   always_comb begin
      s_owed     = owed_ff;
      s_ascii    = ascii_ff;
      s_budget   = mid_ff ? budget_ff : char_budget;
      s_fixed    = fixed_ff;
      s_fverdict = fverdict_ff;
      s_freason  = freason_ff;
      if (!fixed_ff) begin
         if (limit_enable && (s_budget == '0)) begin
            // budget used up: decide on what was seen so far
            s_fixed    = 1'b1;
            s_fverdict = !ascii_ff;
            s_freason  = REASON_BUDGET;
         end else begin
            // one character per ascii byte and per lead byte
            if ((!high || (owed_ff == '0)) && limit_enable) begin
               s_budget = s_budget - 1'b1;
            end
            if (high) begin
               s_ascii = 1'b0;
            end
            if (owed_ff == '0) begin
               if (high) begin
                  if (lead_n == '0) begin
                     s_fixed    = 1'b1;
                     s_fverdict = 1'b0;
                     s_freason  = REASON_BAD_LEAD;
                  end else begin
                     s_owed = lead_n - 1'b1;
                  end
               end
            end else if (item.byte_in[7:6] != 2'b10) begin
               s_fixed    = 1'b1;
               s_fverdict = 1'b0;
               s_freason  = REASON_BAD_CONT;
            end else begin
               s_owed = owed_ff - 1'b1;
            end
         end
      end
   end

   // commit, clearing everything at the end of a string
   always_comb begin
      owed_in     = owed_ff;
      ascii_in    = ascii_ff;
      budget_in   = budget_ff;
      fixed_in    = fixed_ff;
      fverdict_in = fverdict_ff;
      freason_in  = freason_ff;
      mid_in      = mid_ff;
      if (item_take) begin
         if (item.is_last) begin
            owed_in     = '0;
            ascii_in    = 1'b1;
            budget_in   = '0;
            fixed_in    = 1'b0;
            fverdict_in = 1'b0;
            freason_in  = REASON_VALID;
            mid_in      = 1'b0;
         end else begin
            owed_in     = s_owed;
            ascii_in    = s_ascii;
            budget_in   = s_budget;
            fixed_in    = s_fixed;
            fverdict_in = s_fverdict;
            freason_in  = s_freason;
            mid_in      = 1'b1;
         end
      end
   end

   // verdict for the last byte
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_utf8_in   = rsp_utf8_ff;
      rsp_reason_in = rsp_reason_ff;
      if (item_take && item.is_last) begin
         rsp_valid_in = 1'b1;
         if (s_fixed) begin
            rsp_utf8_in   = s_fverdict;
            rsp_reason_in = s_freason;
         end else if (s_owed != '0) begin
            rsp_utf8_in   = 1'b0;
            rsp_reason_in = REASON_TRUNCATED;
         end else if (s_ascii) begin
            rsp_utf8_in   = 1'b0;
            rsp_reason_in = REASON_ALL_ASCII;
         end else begin
            rsp_utf8_in   = 1'b1;
            rsp_reason_in = REASON_VALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff      <= '0;
         ascii_ff     <= 1'b1;
         budget_ff    <= '0;
         fixed_ff     <= 1'b0;
         fverdict_ff  <= 1'b0;
         freason_ff   <= REASON_VALID;
         mid_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         owed_ff      <= owed_in;
         ascii_ff     <= ascii_in;
         budget_ff    <= budget_in;
         fixed_ff     <= fixed_in;
         fverdict_ff  <= fverdict_in;
         freason_ff   <= freason_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_utf8_ff   <= rsp_utf8_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_utf8 = rsp_utf8_ff;
   assign rsp_reason  = rsp_reason_ff;

`ifndef ASSERT_OFF
   // at most five continuation bytes are ever owed
   a_owed_range: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= 3'd5)
      else $error("owed continuation count out of range");

   // a decided verdict carries an early reason only
   a_fixed_reason: assert property (@(posedge clock) disable iff (reset)
      fixed_ff |-> (freason_ff == REASON_BAD_LEAD || freason_ff == REASON_BAD_CONT ||
                    freason_ff == REASON_BUDGET))
      else $error("fixed verdict with unexpected reason");

   // a taken last byte always shows a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.is_last) |=> rsp_valid_ff)
      else $error("last byte taken without result");

   // a positive verdict only with reason valid or budget reached
   a_utf8_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_utf8_ff) |->
         (rsp_reason_ff == REASON_VALID || rsp_reason_ff == REASON_BUDGET))
      else $error("positive verdict with error reason");

   // string state is clear between strings
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !mid_ff |-> (owed_ff == '0 && ascii_ff && !fixed_ff))
      else $error("string state not clear between strings");
`endif

endmodule
